/* design/arab_pkg.sv */
// Shared constants, register indexes and control/status types for the boxcar
// sample-rate adjuster. No dependencies; imported by every other design file.
package arab_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int ACC_BITS       = SAMPLE_BITS + 8;
  localparam int RATE_BITS      = 7;
  localparam int MAX_REPS       = 64;
  localparam int CFG_INDEX_BITS = 2;
  localparam int DIV_CNT_BITS   = $clog2(ACC_BITS + 1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_IN_RATE  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_RATE = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOWNMIX  = CFG_INDEX_BITS'(2);

  typedef struct packed {
    logic [RATE_BITS-1:0] in_rate;
    logic [RATE_BITS-1:0] out_rate;
    logic                 downmix_enable;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic step;
    logic commit;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic reps_zero;
    logic hit;
    logic div_done;
    logic out_free;
    logic has_pending;
  } dp_stat_t;

endpackage

/* design/audio_rate_adjust_boxcar.sv */
// Boxcar rational sample-rate adjuster. Each item runs R accumulate steps,
// where R = min(out_rate, 64), and every result those steps cause passes
// through a bit-serial divider. Items are processed one at a time; results
// leave through an output register. Synchronous reset clears sum, phase and
// handshakes; the registers return to in_rate 1, out_rate 1, downmix on.
module audio_rate_adjust_boxcar (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [arab_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [arab_pkg::RATE_BITS-1:0]           cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [arab_pkg::SAMPLE_BITS-1:0]  sample_left,
  input  logic signed [arab_pkg::SAMPLE_BITS-1:0]  sample_right,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [arab_pkg::SAMPLE_BITS-1:0]  sample_out,
  output logic                                     last
);
  import arab_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_rate        <= RATE_BITS'(1);
      cfg.out_rate       <= RATE_BITS'(1);
      cfg.downmix_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IN_RATE:  cfg.in_rate        <= cfg_data;
        REG_OUT_RATE: cfg.out_rate       <= cfg_data;
        REG_DOWNMIX:  cfg.downmix_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  arab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  arab_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .last         (last)
  );

endmodule

/* design/arab_ctrl.sv */
// Sequencing state machine for the boxcar sample-rate adjuster.
// Depends on arab_pkg for the command and status types.
module arab_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  arab_pkg::dp_stat_t stat,
  output arab_pkg::dp_cmd_t  cmd
);
  import arab_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    STEP,
    DIV,
    RESULT,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_ok;

  assign in_ready = (state == IDLE);
  // A pending result may only move on once the output register can take it.
  assign out_ok = stat.out_free || !stat.has_pending;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = STEP;
        end
      end
      STEP: begin
        if (stat.reps_zero) begin
          state_next = FINISH;
        end else begin
          cmd.step = 1'b1;
          if (stat.hit) begin
            state_next = DIV;
          end
        end
      end
      DIV: begin
        if (stat.div_done) begin
          state_next = RESULT;
        end
      end
      RESULT: begin
        if (out_ok) begin
          cmd.commit = 1'b1;
          state_next = STEP;
        end
      end
      FINISH: begin
        if (out_ok) begin
          cmd.flush  = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/arab_datapath.sv */
// Accumulator, phase counter, iterative divider, pending result and output
// register of the boxcar sample-rate adjuster. Depends on arab_pkg.
module arab_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  arab_pkg::cfg_t                       cfg,
  input  arab_pkg::dp_cmd_t                    cmd,
  output arab_pkg::dp_stat_t                   stat,
  input  logic signed [arab_pkg::SAMPLE_BITS-1:0] sample_left,
  input  logic signed [arab_pkg::SAMPLE_BITS-1:0] sample_right,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [arab_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                 last
);
  import arab_pkg::*;

  localparam logic [ACC_BITS-1:0] POS_LIMIT =
    ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [ACC_BITS-1:0] NEG_LIMIT = ACC_BITS'(64'd1 << (SAMPLE_BITS - 1));

  logic [SAMPLE_BITS:0]          pair_sum;
  logic [SAMPLE_BITS-1:0]        mono;
  logic [RATE_BITS-1:0]          divisor_cfg;
  logic [RATE_BITS-1:0]          reps_cfg;
  logic [ACC_BITS-1:0]           sample;
  logic [ACC_BITS-1:0]           accum;
  logic [ACC_BITS-1:0]           accum_inc;
  logic [ACC_BITS-1:0]           accum_mag;
  logic [RATE_BITS-1:0]          phase;
  logic [RATE_BITS-1:0]          phase_inc;
  logic [RATE_BITS-1:0]          rep_cnt;
  logic [RATE_BITS-1:0]          rem;
  logic [RATE_BITS-1:0]          divisor;
  logic [ACC_BITS-1:0]           quo;
  logic [ACC_BITS-1:0]           quo_neg;
  logic                          neg;
  logic [DIV_CNT_BITS-1:0]       div_cnt;
  logic [RATE_BITS:0]            trial;
  logic [SAMPLE_BITS-1:0]        q_sat;
  logic [SAMPLE_BITS-1:0]        pending;
  logic                          has_pending;
  logic                          out_load;

  // Floor of the pair average is the top bits of the widened sum.
  assign pair_sum = {sample_left[SAMPLE_BITS-1], sample_left}
                  + {sample_right[SAMPLE_BITS-1], sample_right};
  assign mono = cfg.downmix_enable ? pair_sum[SAMPLE_BITS:1] : sample_left;

  assign divisor_cfg = (cfg.in_rate == '0) ? RATE_BITS'(1) : cfg.in_rate;
  assign reps_cfg    = (cfg.out_rate > RATE_BITS'(MAX_REPS)) ? RATE_BITS'(MAX_REPS)
                                                             : cfg.out_rate;

  assign accum_inc = accum + sample;
  assign phase_inc = phase + RATE_BITS'(1);
  assign accum_mag = accum_inc[ACC_BITS-1] ? (~accum_inc + ACC_BITS'(1)) : accum_inc;

  // Restoring division on the magnitude, one quotient bit per cycle.
  assign trial   = {rem, quo[ACC_BITS-1]} - {1'b0, divisor};
  assign quo_neg = ~quo + ACC_BITS'(1);

  always_comb begin
    if (!neg) begin
      q_sat = (quo > POS_LIMIT) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : quo[SAMPLE_BITS-1:0];
    end else begin
      q_sat = (quo > NEG_LIMIT) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                : quo_neg[SAMPLE_BITS-1:0];
    end
  end

  assign out_load = (cmd.commit || cmd.flush) && has_pending;

  assign stat.reps_zero   = (rep_cnt == '0);
  assign stat.hit         = (phase_inc == divisor_cfg);
  assign stat.div_done    = (div_cnt == '0);
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.has_pending = has_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum       <= '0;
      phase       <= '0;
      rep_cnt     <= '0;
      div_cnt     <= '0;
      has_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        rep_cnt     <= reps_cfg;
        has_pending <= 1'b0;
      end
      if (cmd.step) begin
        rep_cnt <= rep_cnt - RATE_BITS'(1);
        if (stat.hit) begin
          accum   <= '0;
          phase   <= '0;
          div_cnt <= DIV_CNT_BITS'(ACC_BITS);
        end else begin
          accum <= accum_inc;
          phase <= phase_inc;
        end
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - DIV_CNT_BITS'(1);
      end
      if (cmd.commit) begin
        has_pending <= 1'b1;
      end
      if (cmd.flush) begin
        has_pending <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sample <= {{(ACC_BITS-SAMPLE_BITS){mono[SAMPLE_BITS-1]}}, mono};
    end
    if (cmd.step && stat.hit) begin
      quo     <= accum_mag;
      rem     <= '0;
      neg     <= accum_inc[ACC_BITS-1];
      divisor <= divisor_cfg;
    end else if (div_cnt != '0) begin
      quo <= {quo[ACC_BITS-2:0], !trial[RATE_BITS]};
      rem <= trial[RATE_BITS] ? {rem[RATE_BITS-2:0], quo[ACC_BITS-1]}
                              : trial[RATE_BITS-1:0];
    end
    if (cmd.commit) begin
      pending <= q_sat;
    end
    if (out_load) begin
      sample_out <= pending;
      last       <= cmd.flush;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> stat.out_free)
    else $error("output register loaded while a result still waits");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && stat.hit) |-> (div_cnt == '0))
    else $error("divider restarted while busy");

  a_commit_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.div_done)
    else $error("quotient taken before the divider finished");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush && has_pending) |=> (out_valid && last && !has_pending))
    else $error("final result of an item not marked last");

endmodule

/* dv/boxcar_average_checker.sv */
// Checker for the boxcar sample-rate adjuster: tracks register writes, predicts
// the averaged samples for every accepted stereo pair and compares each output
// transfer. Depends on arab_pkg for widths and register indexes.
module boxcar_average_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [arab_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [arab_pkg::RATE_BITS-1:0]          cfg_data,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic signed [arab_pkg::SAMPLE_BITS-1:0] sample_left,
  input  logic signed [arab_pkg::SAMPLE_BITS-1:0] sample_right,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [arab_pkg::SAMPLE_BITS-1:0] sample_out,
  input  logic                                    last,
  output int                                      fail_count,
  output int                                      expected_left,
  output int                                      results_checked
);
  import arab_pkg::*;

  localparam int SAT_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAT_MIN = -(2 ** (SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } avg_result_t;

  avg_result_t                  expected_samples[$];
  avg_result_t                  oldest;
  logic [RATE_BITS-1:0]         in_rate_q;
  logic [RATE_BITS-1:0]         out_rate_q;
  logic                         downmix_q;
  logic signed [ACC_BITS-1:0]   running_sum;
  logic [RATE_BITS-1:0]         step_count;
  int                           mismatches = 0;
  int                           checked = 0;

  // Adds the chosen sample to the boxcar sum once per output-rate unit (at most
  // MAX_REPS) and queues an average when the step count meets the input rate.
  task automatic accumulate_pair(input logic signed [SAMPLE_BITS-1:0] left_val,
                                 input logic signed [SAMPLE_BITS-1:0] right_val);
    logic signed [SAMPLE_BITS:0]   pair_sum;
    logic signed [SAMPLE_BITS-1:0] chosen;
    logic [RATE_BITS-1:0]          divisor;
    int                            reps;
    int                            quotient;
    int                            queued_before;
    avg_result_t                   entry;
    queued_before = expected_samples.size();
    pair_sum = left_val + right_val;
    chosen = downmix_q ? SAMPLE_BITS'(pair_sum >>> 1) : left_val;
    divisor = (in_rate_q == '0) ? RATE_BITS'(1) : in_rate_q;
    reps = (int'(out_rate_q) > MAX_REPS) ? MAX_REPS : int'(out_rate_q);
    for (int k = 0; k < reps; k++) begin
      running_sum = running_sum + ACC_BITS'(chosen);
      step_count = step_count + RATE_BITS'(1);
      if (step_count == divisor) begin
        quotient = int'(running_sum) / int'(divisor);
        if (quotient > SAT_MAX) quotient = SAT_MAX;
        if (quotient < SAT_MIN) quotient = SAT_MIN;
        entry.sample = SAMPLE_BITS'(quotient);
        entry.last = 1'b0;
        expected_samples.push_back(entry);
        running_sum = '0;
        step_count = '0;
      end
    end
    if (expected_samples.size() > queued_before) begin
      entry = expected_samples.pop_back();
      entry.last = 1'b1;
      expected_samples.push_back(entry);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_rate_q = RATE_BITS'(1);
      out_rate_q = RATE_BITS'(1);
      downmix_q = 1'b1;
      running_sum = '0;
      step_count = '0;
      expected_samples.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IN_RATE: begin
            in_rate_q = cfg_data;
          end
          REG_OUT_RATE: begin
            out_rate_q = cfg_data;
          end
          REG_DOWNMIX: begin
            downmix_q = cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      // Outputs are compared before the new pair is predicted: a result can
      // never leave in the same cycle as the transfer that causes it.
      if (out_valid && out_ready) begin
        checked++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected nothing, actual sample_out=%0d last=%0b",
                   $time, sample_out, last);
        end else begin
          oldest = expected_samples.pop_front();
          if (sample_out !== oldest.sample) begin
            mismatches++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, oldest.sample, sample_out);
          end
          if (last !== oldest.last) begin
            mismatches++;
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, oldest.last, last);
          end
        end
      end
      if (in_valid && in_ready) accumulate_pair(sample_left, sample_right);
    end
    fail_count <= mismatches;
    expected_left <= expected_samples.size();
    results_checked <= checked;
  end

endmodule

/* dv/audio_rate_adjust_boxcar_test.sv */
// Top of the boxcar sample-rate adjuster testbench: clock, reset, register
// writes, stereo-pair stimulus, output back-pressure and the verdict. Depends on
// arab_pkg, audio_rate_adjust_boxcar and boxcar_average_checker.
module audio_rate_adjust_boxcar_test;
  import arab_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 600;
  localparam int ITEM_TARGET  = 370;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = CFG_INDEX_BITS'(3);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [RATE_BITS-1:0]          cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_left = '0;
  logic signed [SAMPLE_BITS-1:0] sample_right = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last;

  int fail_count;
  int expected_left;
  int results_checked;
  int pairs_sent = 0;
  int settings_run = 0;
  bit hold_request = 1'b0;

  audio_rate_adjust_boxcar u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .last         (last)
  );

  boxcar_average_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_left     (sample_left),
    .sample_right    (sample_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample_out      (sample_out),
    .last            (last),
    .fail_count      (fail_count),
    .expected_left   (expected_left),
    .results_checked (results_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return SAMPLE_MAX;
    if (roll < 10) return SAMPLE_MIN;
    if (roll < 14) return -16'sd1;
    if (roll < 30) return SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
    return SAMPLE_BITS'($urandom());
  endfunction

  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] left_val,
                           input logic signed [SAMPLE_BITS-1:0] right_val,
                           input bit with_gaps);
    int gap;
    gap = with_gaps ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_left <= left_val;
    sample_right <= right_val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
  endtask

  // Waits for every expected sample, then gives a pair that produced no
  // output time to finish accumulating before the registers change.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [RATE_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_rates(input logic [RATE_BITS-1:0] in_rate,
                             input logic [RATE_BITS-1:0] out_rate,
                             input logic [RATE_BITS-1:0] downmix_word);
    write_reg(REG_IN_RATE, in_rate);
    write_reg(REG_OUT_RATE, out_rate);
    write_reg(REG_DOWNMIX, downmix_word);
    settings_run++;
  endtask

  task automatic pick_rates(output logic [RATE_BITS-1:0] in_rate,
                            output logic [RATE_BITS-1:0] out_rate);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      in_rate = RATE_BITS'($urandom_range(1, 12));
      out_rate = RATE_BITS'($urandom_range(1, 6));
    end else if (roll < 65) begin
      in_rate = RATE_BITS'($urandom_range(1, 4));
      out_rate = RATE_BITS'($urandom_range(8, 32));
    end else if (roll < 75) begin
      in_rate = RATE_BITS'($urandom_range(60, 127));
      out_rate = RATE_BITS'($urandom_range(1, 4));
    end else if (roll < 80) begin
      in_rate = '0;
      out_rate = RATE_BITS'($urandom_range(1, 8));
    end else if (roll < 85) begin
      in_rate = RATE_BITS'($urandom_range(0, 127));
      out_rate = '0;
    end else if (roll < 90) begin
      in_rate = RATE_BITS'($urandom_range(1, 127));
      out_rate = RATE_BITS'(MAX_REPS);
    end else if (roll < 95) begin
      in_rate = RATE_BITS'($urandom_range(1, 127));
      out_rate = RATE_BITS'($urandom_range(MAX_REPS + 1, 127));
    end else begin
      in_rate = 7'd127;
      out_rate = RATE_BITS'(MAX_REPS);
    end
  endtask

  initial begin : stimulus
    logic [RATE_BITS-1:0] in_rate;
    logic [RATE_BITS-1:0] out_rate;
    int                   pair_count;
    bit                   gapped;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // An index with no register behind it must leave the settings alone.
    write_reg(REG_UNUSED, RATE_BITS'($urandom_range(0, 127)));

    // Reset settings: downmix on, one-to-one rates; rounding of odd sums.
    send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_pair(-16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    drain_results();
    // Left only; the upper bits of the downmix word are ignored.
    apply_rates(7'd1, 7'd1, 7'h7E);
    send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_pair(16'sd5, -16'sd20000, 1'b0);
    drain_results();
    // A zero input rate behaves as one: sixty-four outputs per pair.
    apply_rates(7'd0, RATE_BITS'(MAX_REPS), 7'h01);
    send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    send_pair(16'sd12345, -16'sd3, 1'b1);
    drain_results();
    // Output rate beyond sixty-four is clipped; leaves a partial sum behind.
    apply_rates(7'd3, 7'd127, 7'h00);
    send_pair(-16'sd7, 16'sd0, 1'b0);
    drain_results();
    // A zero output rate accumulates nothing.
    apply_rates(7'd5, 7'd0, 7'h00);
    send_pair(16'sd1000, 16'sd1000, 1'b0);
    send_pair(-16'sd1000, 16'sd5, 1'b0);
    drain_results();
    // Lowering the input rate mid-stream makes the count wrap, and the large
    // sum then clips at the positive limit.
    apply_rates(7'd127, 7'd100, 7'h00);
    send_pair(SAMPLE_MAX, 16'sd0, 1'b0);
    drain_results();
    apply_rates(7'd1, 7'd100, 7'h00);
    send_pair(SAMPLE_MAX, 16'sd0, 1'b0);
    drain_results();
    // Same again towards the negative limit.
    apply_rates(7'd127, RATE_BITS'(MAX_REPS), 7'h00);
    send_pair(SAMPLE_MIN, 16'sd0, 1'b0);
    drain_results();
    apply_rates(7'd1, RATE_BITS'(MAX_REPS), 7'h00);
    send_pair(SAMPLE_MIN, 16'sd0, 1'b0);
    send_pair(SAMPLE_MIN, 16'sd0, 1'b0);
    drain_results();

    // Back-to-back pairs while the receiver holds off, so the block fills up.
    apply_rates(7'd1, 7'd2, 7'h01);
    for (int i = 0; i < 24; i++) begin
      if (i == 4) hold_request <= 1'b1;
      send_pair(pick_sample(), pick_sample(), 1'b0);
    end
    drain_results();

    while (pairs_sent < ITEM_TARGET) begin
      pick_rates(in_rate, out_rate);
      apply_rates(in_rate, out_rate, RATE_BITS'($urandom_range(0, 127)));
      pair_count = (out_rate > 16) ? 6 : $urandom_range(20, 32);
      gapped = ($urandom_range(0, 3) != 0);
      repeat (pair_count) send_pair(pick_sample(), pick_sample(), gapped);
      drain_results();
    end

    $display("Sent %0d stereo pairs under %0d rate settings; %0d averaged samples compared.",
             pairs_sent, settings_run, results_checked);
    $display("Covered clipped and zero rates, count wrap after rate changes and clipping.");
    if (expected_left != 0)
      $display("%0t: %0d expected samples never arrived", $time, expected_left);
    if (fail_count == 0 && expected_left == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : sink
    int  burst;
    int  gap;
    bit  hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 250) : $urandom_range(1, 8);
      repeat (burst) begin
        @(posedge clk);
        if (hold_request && !hold_done) break;
      end
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = idle_length();
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
design/arab_pkg.sv
design/arab_ctrl.sv
design/arab_datapath.sv
design/audio_rate_adjust_boxcar.sv
dv/boxcar_average_checker.sv
dv/audio_rate_adjust_boxcar_test.sv
